// ----- rtl/bdasc_pkg.sv -----
package bdasc_pkg;

  // Decimal places produced by compare and subtract; the ones digit is what remains.
  localparam int NumSplit = 4;
  localparam int NumDigits = NumSplit + 1;
  localparam int MaxChars = NumDigits + 1;
  localparam int ProdW = 20;

  typedef logic [15:0] mag_t;
  typedef logic [3:0] digit_t;
  typedef logic [5:0] char_t;
  typedef logic [2:0] len_t;
  typedef digit_t [NumSplit-1:0] digs_t;

  typedef struct packed {
    digit_t d;
    mag_t   r;
  } split_t;

  localparam char_t CharZero  = 6'h30;
  localparam char_t CharMinus = 6'd45;

  localparam logic [ProdW-1:0] PlaceWeight [NumSplit] = '{
    20'd10000, 20'd1000, 20'd100, 20'd10
  };

  // Quotient digit by nine parallel compares against constant multiples, then one subtract.
  function automatic split_t split_digit(mag_t m, logic [ProdW-1:0] w);
    split_t s;
    logic [ProdW-1:0] p;
    s.d = '0;
    for (int k = 1; k < 10; k++) begin
      if ({4'b0, m} >= ProdW'(k) * w) s.d = digit_t'(k);
    end
    p = ProdW'(s.d) * w;
    s.r = mag_t'({4'b0, m} - p);
    return s;
  endfunction

endpackage

// ----- rtl/binary_to_decimal_ascii.sv -----
// Binary to decimal ASCII converter for 16-bit values.
//
// The input channel (in_valid, in_stall) carries one number per beat: value
// and mode, where mode 1 reads value as two's complement. The output channel
// (out_valid, out_stall) carries one ASCII character per beat, most
// significant first, with leading zeros suppressed. A negative signed number
// starts with '-'. The final character of each number has last set.
//
// The conversion runs through five register stages: sign and magnitude, then
// one decimal place per stage (ten thousands, thousands, hundreds, tens). The
// last stage loads the finished number into the serializer. A number gives
// one to six characters and the output channel moves one per cycle unless
// out_stall is high; a number waiting in the last stage loads as the last
// character of the current one is taken. Numbers queue in the pipeline while
// the serializer drains, so inputs are taken back to back until the stages
// fill.
//
// Reset clears all stage valid bits and empties the serializer. When the
// receiver stalls, the current character holds and the stall propagates back
// stage by stage to in_stall; nothing is dropped or repeated.
module binary_to_decimal_ascii
  import bdasc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] value,
  input  logic        mode,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  character,
  output logic        last
);

  localparam int NumStages = NumSplit + 1;

  // Stage registers. Stage 0 holds sign and magnitude; stage i holds the
  // first i digits and the remainder still to be split.
  logic   s_valid [NumStages];
  mag_t   s_mag   [NumStages];
  logic   s_neg   [NumStages];
  digs_t  s_dig   [NumStages];

  logic   adv      [NumStages];
  split_t sp       [NumSplit];
  digs_t  dig_next [NumSplit];

  // Serializer: a shift line of characters with a remaining count.
  char_t  ser_chr [MaxChars];
  len_t   ser_rem;
  logic   ser_ready;
  logic   out_take;

  // Packing of the finished number from the last stage.
  digit_t dig_all [NumDigits];
  char_t  pk_chr  [MaxChars];
  len_t   pk_len;
  len_t   lead;

  assign out_valid = (ser_rem != '0);
  assign character = ser_chr[0];
  assign last      = (ser_rem == len_t'(1));
  assign out_take  = out_valid && !out_stall;
  assign ser_ready = !out_valid || (out_take && last);

  // A stage moves on when it is empty or its successor takes its contents.
  always_comb begin
    adv[NumStages-1] = !s_valid[NumStages-1] || ser_ready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      adv[i] = !s_valid[i] || adv[i+1];
    end
  end

  assign in_stall = !adv[0];

  // Each stage splits off one decimal place and slots it into the digit set.
  always_comb begin
    for (int i = 0; i < NumSplit; i++) begin
      sp[i]          = split_digit(s_mag[i], PlaceWeight[i]);
      dig_next[i]    = s_dig[i];
      dig_next[i][i] = sp[i].d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumStages; i++) s_valid[i] <= 1'b0;
    end else begin
      if (adv[0]) s_valid[0] <= in_valid;
      for (int i = 1; i < NumStages; i++) begin
        if (adv[i]) s_valid[i] <= s_valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      s_neg[0] <= mode && value[15];
      s_mag[0] <= (mode && value[15]) ? mag_t'(~value + 16'd1) : value;
      s_dig[0] <= '0;
    end
    for (int i = 1; i < NumStages; i++) begin
      if (adv[i] && s_valid[i-1]) begin
        s_neg[i] <= s_neg[i-1];
        s_mag[i] <= sp[i-1].r;
        s_dig[i] <= dig_next[i-1];
      end
    end
  end

  // Leading zero suppression: the ones digit always prints.
  always_comb begin
    int j;
    for (int i = 0; i < NumSplit; i++) dig_all[i] = s_dig[NumStages-1][i];
    dig_all[NumDigits-1] = s_mag[NumStages-1][3:0];
    lead = len_t'(NumDigits - 1);
    for (int i = NumSplit - 1; i >= 0; i--) begin
      if (dig_all[i] != '0) lead = len_t'(i);
    end
    pk_len = len_t'(NumDigits) - lead + len_t'(s_neg[NumStages-1]);
    for (int k = 0; k < MaxChars; k++) begin
      j = k + int'(lead) - int'(s_neg[NumStages-1]);
      if (s_neg[NumStages-1] && k == 0) begin
        pk_chr[k] = CharMinus;
      end else if (j >= 0 && j < NumDigits) begin
        pk_chr[k] = CharZero + char_t'(dig_all[j]);
      end else begin
        pk_chr[k] = CharZero;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_rem <= '0;
    end else if (ser_ready && s_valid[NumStages-1]) begin
      ser_rem <= pk_len;
    end else if (ser_ready) begin
      ser_rem <= '0;
    end else if (out_take) begin
      ser_rem <= ser_rem - len_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ser_ready && s_valid[NumStages-1]) begin
      for (int k = 0; k < MaxChars; k++) ser_chr[k] <= pk_chr[k];
    end else if (out_take) begin
      for (int k = 0; k < MaxChars - 1; k++) ser_chr[k] <= ser_chr[k+1];
    end
  end

  // A number never holds more characters than the widest result.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    ser_rem <= len_t'(MaxChars))
    else $error("serializer count out of range");

  // A minus sign is never the final character.
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && character == CharMinus) |-> !last)
    else $error("minus sign marked last");

  // After a character that is not last, a digit follows at once.
  a_digit_follows: assert property (@(posedge clk) disable iff (rst)
    (out_take && !last) |=> (out_valid && character != CharMinus))
    else $error("number broken off before its last character");

  // Output characters are the minus sign or a decimal digit.
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (character == CharMinus ||
                   (character >= CharZero && character <= CharZero + char_t'(9))))
    else $error("character outside the decimal set");

endmodule
